// ----- rtl/sensor_packet_crc_validator_unit_assert.svh -----
// Assertion helpers shared by the RTL. Each check is clocked on clk and
// held off while arst_n is low.
`ifndef SENSOR_PACKET_CRC_VALIDATOR_UNIT_ASSERT_SVH
`define SENSOR_PACKET_CRC_VALIDATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPCV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPCV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/spcv_pkg.sv -----
`default_nettype none

package spcv_pkg;

	localparam int ID_BYTES_DEF = 16;
	localparam int ID_SLOTS     = 16;
	localparam int IDX_W        = 5;

	localparam logic [7:0]  DATA_TYPE = 8'h01;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'h1021;
	localparam logic [15:0] CRC_TOP   = 16'h8000;

	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_BAD_CRC  = 2'd1;
	localparam logic [1:0] ST_IGNORED  = 2'd2;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       first_byte;
	} byte_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] id_upper;
		logic [63:0] id_lower;
		logic [15:0] people_count;
		logic [7:0]  battery_level;
		logic [7:0]  hops;
		logic [31:0] stamp;
		logic [31:0] good_total;
		logic [31:0] bad_total;
	} result_word_t;

	// Handshake between the byte register and the framing logic.
	typedef struct packed {
		logic valid;
		logic last;
	} frame_ctl_t;

	// One byte of CRC-16, MSB first, eight unrolled shift steps.
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 16'h0000)
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/spcv_in_stage.sv -----
`default_nettype none

module spcv_in_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_valid,
	input  wire spcv_pkg::byte_word_t byte_word,
	input  wire logic                 hold,
	output logic                      valid_s1,
	output spcv_pkg::byte_word_t      word_s1
);

	// hold the staged word while the framing logic cannot take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!hold) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold && byte_valid) begin
			word_s1 <= byte_word;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/spcv_frame.sv -----
`default_nettype none

module spcv_frame #(
	parameter int ID_BYTES = spcv_pkg::ID_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire spcv_pkg::byte_word_t word_s1,
	output logic                      is_last,
	output spcv_pkg::result_word_t    result
);

	localparam int W = spcv_pkg::IDX_W;
	localparam logic [W-1:0] POS_COUNT = W'(1 + ID_BYTES);
	localparam logic [W-1:0] POS_BATT  = W'(3 + ID_BYTES);
	localparam logic [W-1:0] POS_HOPS  = W'(4 + ID_BYTES);
	localparam logic [W-1:0] POS_TIME  = W'(5 + ID_BYTES);
	localparam logic [W-1:0] POS_CRC   = W'(9 + ID_BYTES);
	localparam logic [W-1:0] POS_LAST  = W'(10 + ID_BYTES);

	logic [W-1:0] byte_index_q;
	logic [15:0]  crc_q;
	logic [7:0]   type_q;
	logic [7:0]   id_q [ID_BYTES];
	logic [15:0]  count_q;
	logic [7:0]   batt_q;
	logic [7:0]   hop_q;
	logic [31:0]  time_q;
	logic [15:0]  crc_field_q;
	logic [31:0]  good_q;
	logic [31:0]  bad_q;

	logic [W-1:0] idx;
	logic [7:0]   b;
	logic [15:0]  crc_base;
	logic [15:0]  crc_new;
	logic [15:0]  rx_crc;
	logic [1:0]   status;
	logic [31:0]  good_after;
	logic [31:0]  bad_after;
	logic [127:0] id_all;

	assign b   = word_s1.rx_byte;
	assign idx = word_s1.first_byte ? '0 : byte_index_q;
	assign is_last = (idx == POS_LAST);

	assign crc_base = (idx == '0) ? spcv_pkg::CRC_INIT : crc_q;
	assign crc_new  = (idx < POS_CRC) ? spcv_pkg::crc_update(crc_base, b) : crc_base;
	assign rx_crc   = {b, crc_field_q[7:0]};

	always_comb begin
		priority if (type_q != spcv_pkg::DATA_TYPE) begin
			status = spcv_pkg::ST_IGNORED;
		end else if (crc_new == rx_crc) begin
			status = spcv_pkg::ST_ACCEPTED;
		end else begin
			status = spcv_pkg::ST_BAD_CRC;
		end
	end

	assign good_after = (status == spcv_pkg::ST_ACCEPTED) ? good_q + 32'd1 : good_q;
	assign bad_after  = (status == spcv_pkg::ST_BAD_CRC) ? bad_q + 32'd1 : bad_q;

	// id slots beyond the configured length read as zero
	for (genvar p = 0; p < spcv_pkg::ID_SLOTS; p++) begin : g_id
		if (p < ID_BYTES) begin : g_used
			assign id_all[127 - 8*p -: 8] = id_q[p];
		end else begin : g_unused
			assign id_all[127 - 8*p -: 8] = 8'h00;
		end
	end

	always_comb begin
		result.status        = status;
		result.id_upper      = id_all[127:64];
		result.id_lower      = id_all[63:0];
		result.people_count  = count_q;
		result.battery_level = batt_q;
		result.hops          = hop_q;
		result.stamp         = time_q;
		result.good_total    = good_after;
		result.bad_total     = bad_after;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			crc_q        <= spcv_pkg::CRC_INIT;
			type_q       <= 8'h00;
			count_q      <= 16'h0000;
			batt_q       <= 8'h00;
			hop_q        <= 8'h00;
			time_q       <= 32'h0;
			crc_field_q  <= 16'h0000;
			good_q       <= 32'h0;
			bad_q        <= 32'h0;
		end else if (adv) begin
			byte_index_q <= is_last ? '0 : idx + W'(1);
			crc_q        <= is_last ? spcv_pkg::CRC_INIT : crc_new;
			priority if (idx == '0) begin
				type_q <= b;
			end else if (idx < POS_COUNT) begin
				// id bytes live in their own block
			end else if (idx == POS_COUNT) begin
				count_q <= {8'h00, b};
			end else if (idx == POS_COUNT + W'(1)) begin
				count_q <= {b, count_q[7:0]};
			end else if (idx == POS_BATT) begin
				batt_q <= b;
			end else if (idx == POS_HOPS) begin
				hop_q <= b;
			end else if (idx == POS_TIME) begin
				time_q <= {24'h0, b};
			end else if (idx < POS_CRC) begin
				for (int j = 1; j < 4; j++) begin
					if (idx == POS_TIME + W'(j))
						time_q[8*j +: 8] <= time_q[8*j +: 8] | b;
				end
			end else if (idx == POS_CRC) begin
				crc_field_q <= {8'h00, b};
			end else begin
				crc_field_q <= rx_crc;
				good_q      <= good_after;
				bad_q       <= bad_after;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < ID_BYTES; k++) begin
				if (idx == W'(k + 1))
					id_q[k] <= b;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/spcv_out_stage.sv -----
`default_nettype none

module spcv_out_stage (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire spcv_pkg::result_word_t next_word,
	input  wire logic                   result_stall,
	output logic                        result_valid,
	output spcv_pkg::result_word_t      result_word,
	output logic                        free
);

	logic valid_q;

	assign result_valid = valid_q;
	assign free = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_word <= next_word;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sensor_packet_crc_validator_unit.sv -----
// Sensor packet CRC check. Packet bytes enter on the byte channel
// (byte_valid / byte_stall / byte_word), one word per cycle while byte_stall is low, in wire order:
// type, id, count, battery, hops, timestamp, crc. Set first_byte on byte 0
// to restart framing; without it the byte count alone frames the stream.
// A CRC-16 (poly 0x1021, init 0xFFFF) runs over every byte before the crc
// field. On the last byte one word leaves on the result channel
// (result_valid / result_stall / result_word) with status, the packet
// fields and both running totals; other bytes produce nothing.
// Throughput: one byte per cycle while byte_stall is low; the eight-step CRC
// update sits combinationally between the byte register and the framing
// registers. The result word loads when the last byte leaves the byte register.
// When the receiver stalls, the result register holds its word; further
// bytes keep flowing until the next last byte, which waits in the byte
// register, and byte_stall rises until the result is taken.
// Reset clears framing, the CRC, the non-id fields and both totals; the first
// packet after reset writes every id byte before it is reported.
`default_nettype none

`include "sensor_packet_crc_validator_unit_assert.svh"

module sensor_packet_crc_validator_unit #(
	parameter int ID_BYTES = spcv_pkg::ID_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_valid,
	output logic                      byte_stall,
	input  wire spcv_pkg::byte_word_t byte_word,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output spcv_pkg::result_word_t    result_word
);

	logic                   valid_s1;
	spcv_pkg::byte_word_t   word_s1;
	logic                   is_last;
	spcv_pkg::result_word_t frame_result;
	logic                   out_free;
	spcv_pkg::frame_ctl_t   ctl;
	logic                   adv;
	logic                   status_ok;

	// staged byte register
	spcv_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_word  (byte_word),
		.hold       (byte_stall),
		.valid_s1   (valid_s1),
		.word_s1    (word_s1)
	);

	// framing, CRC and field capture
	spcv_frame #(
		.ID_BYTES (ID_BYTES)
	) u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.word_s1 (word_s1),
		.is_last (is_last),
		.result  (frame_result)
	);

	assign ctl.valid = valid_s1;
	assign ctl.last  = is_last;

	// advance a byte unless it closes a packet and the result slot is taken
	assign adv        = ctl.valid && (!ctl.last || out_free);
	assign byte_stall = ctl.valid && !adv;

	// result register
	spcv_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (adv && ctl.last),
		.next_word    (frame_result),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result_word  (result_word),
		.free         (out_free)
	);

	assign status_ok = (result_word.status == spcv_pkg::ST_ACCEPTED) ||
		(result_word.status == spcv_pkg::ST_BAD_CRC) ||
		(result_word.status == spcv_pkg::ST_IGNORED);

	`SPCV_ASSERT_NOW(a_stall_cause, byte_stall, ctl.last && result_valid && result_stall, "stray stall")
	`SPCV_ASSERT_NEXT(a_stage_hold, byte_stall, valid_s1 && $stable(word_s1), "staged word lost")
	`SPCV_ASSERT_NOW(a_status_code, result_valid, status_ok, "bad status code")

endmodule

`default_nettype wire
